// ===== rtl/vab_pkg.sv =====
package vab_pkg;

	localparam int LEVEL_W = 17;
	localparam int KEY_W   = 7;
	localparam int STAGE_W = 3;
	localparam int KIND_W  = 2;
	localparam int VOICE_W = 4;
	localparam int COUNT_W = 5;
	localparam int CIDX_W  = 3;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'd65536;

	localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
	localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
	localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
	localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd3;

	localparam logic [CIDX_W-1:0] REG_MONO    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ATTACK  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_DECAY   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [CIDX_W-1:0] REG_RELEASE = 3'd4;

	typedef struct packed {
		logic [STAGE_W-1:0] stage;
		logic [LEVEL_W-1:0] level;
		logic [KEY_W-1:0]   key;
	} entry_t;

endpackage

// ===== rtl/voice_allocator_adsr_bank.sv =====
// voice state sits in one memory, walked one voice per cycle (one read, at most one write back)
// note off / all off: result strobed after one scan pass; note on also writes the chosen voice first
// tick: step pass then report pass, N results on consecutive cycles, the final one flagged by last
// start is taken only while idle (busy low); a new beat waits until the previous one is finished
// arst_n resets control, config registers (to defaults) and per-voice valid bits; unwritten voices read as off
module voice_allocator_adsr_bank #(
	parameter int NUM_VOICES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [vab_pkg::KIND_W-1:0]   kind,
	input  logic [vab_pkg::KEY_W-1:0]    note,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vab_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [vab_pkg::LEVEL_W-1:0]  cfg_data,
	output logic                         strobe,
	output logic [vab_pkg::VOICE_W-1:0]  voice,
	output logic [vab_pkg::LEVEL_W-1:0]  level,
	output logic [vab_pkg::STAGE_W-1:0]  stage,
	output logic [vab_pkg::KEY_W-1:0]    voice_note,
	output logic [vab_pkg::COUNT_W-1:0]  released_count,
	output logic [vab_pkg::COUNT_W-1:0]  active_count,
	output logic                         last
);

	localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CW = $clog2(NUM_VOICES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ONW  = 3'd2;
	localparam logic [2:0] S_STEP = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	// config registers
	logic                         mono_q;
	logic [vab_pkg::LEVEL_W-1:0]  attack_q, decay_q, sustain_q, release_q;

	logic [2:0]                   state_q;
	logic [vab_pkg::KIND_W-1:0]   kind_q;
	logic [vab_pkg::KEY_W-1:0]    note_q;
	logic [CW-1:0]                addr_q;
	logic                         v_s1;
	logic [IW-1:0]                idx_s1;
	vab_pkg::entry_t              rdata_s1;
	logic                         found_q, have_q;
	logic [IW-1:0]                chosen_q;
	logic [vab_pkg::LEVEL_W-1:0]  lowest_q;
	logic [CW-1:0]                rel_q, act_q, active_q;
	logic [NUM_VOICES-1:0]        vld_q;

	vab_pkg::entry_t              mem [NUM_VOICES];

	logic                         rd_en, pass_done, we, rel_hit;
	logic [IW-1:0]                waddr;
	vab_pkg::entry_t              wdata, cur, stepped;
	logic [vab_pkg::LEVEL_W-1:0]  sus;
	logic                         is_held;

	logic                         strobe_q, last_q;
	logic [vab_pkg::VOICE_W-1:0]  voice_q;
	logic [vab_pkg::LEVEL_W-1:0]  level_q;
	logic [vab_pkg::STAGE_W-1:0]  stage_q;
	logic [vab_pkg::KEY_W-1:0]    key_q;
	logic [CW-1:0]                relout_q, actout_q;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q    <= 1'b0;
			attack_q  <= 17'd655;
			decay_q   <= 17'd655;
			sustain_q <= 17'd45875;
			release_q <= 17'd328;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vab_pkg::REG_MONO:    mono_q    <= cfg_data[0];
				vab_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				vab_pkg::REG_DECAY:   decay_q   <= cfg_data;
				vab_pkg::REG_SUSTAIN: sustain_q <= cfg_data;
				vab_pkg::REG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sus = (sustain_q > vab_pkg::FULL_SCALE) ? vab_pkg::FULL_SCALE : sustain_q;

	assign rd_en = (state_q == S_SCAN || state_q == S_STEP || state_q == S_OUT)
		&& (addr_q < CW'(NUM_VOICES));
	assign pass_done = (addr_q == CW'(NUM_VOICES)) && !v_s1;

	// never-written voices read as off, level 0, key 0
	assign cur = vld_q[idx_s1] ? rdata_s1 : '0;

	assign is_held = (cur.stage == vab_pkg::ST_ATTACK) || (cur.stage == vab_pkg::ST_DECAY)
		|| (cur.stage == vab_pkg::ST_SUSTAIN);

	always_comb begin
		rel_hit = 1'b0;
		if (is_held) begin
			unique case (kind_q)
				vab_pkg::KIND_ALL_OFF:  rel_hit = 1'b1;
				vab_pkg::KIND_NOTE_OFF: rel_hit = (cur.key == note_q);
				vab_pkg::KIND_NOTE_ON:  rel_hit = mono_q && (idx_s1 != '0);
				default:                rel_hit = 1'b0;
			endcase
		end
	end

	// one envelope step
	always_comb begin
		logic [vab_pkg::LEVEL_W:0]   sum;
		logic signed [vab_pkg::LEVEL_W+1:0] dif;
		sum = {1'b0, cur.level} + {1'b0, attack_q};
		dif = '0;
		stepped = cur;
		unique case (cur.stage)
			vab_pkg::ST_ATTACK: begin
				if (sum >= {1'b0, vab_pkg::FULL_SCALE}) begin
					stepped.level = vab_pkg::FULL_SCALE;
					stepped.stage = vab_pkg::ST_DECAY;
				end else begin
					stepped.level = sum[vab_pkg::LEVEL_W-1:0];
				end
			end
			vab_pkg::ST_DECAY: begin
				dif = $signed({2'b00, cur.level}) - $signed({2'b00, decay_q});
				if (dif <= $signed({2'b00, sus})) begin
					stepped.level = sus;
					stepped.stage = vab_pkg::ST_SUSTAIN;
				end else begin
					stepped.level = dif[vab_pkg::LEVEL_W-1:0];
				end
			end
			vab_pkg::ST_RELEASE: begin
				dif = $signed({2'b00, cur.level}) - $signed({2'b00, release_q});
				if (dif <= 0) begin
					stepped.level = '0;
					stepped.stage = vab_pkg::ST_OFF;
				end else begin
					stepped.level = dif[vab_pkg::LEVEL_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = cur;
		priority if (state_q == S_ONW) begin
			we    = 1'b1;
			waddr = chosen_q;
			wdata = '{stage: vab_pkg::ST_ATTACK, level: '0, key: note_q};
		end else if (state_q == S_STEP && v_s1) begin
			we    = 1'b1;
			wdata = stepped;
		end else if (state_q == S_SCAN && v_s1 && rel_hit) begin
			we          = 1'b1;
			wdata.stage = vab_pkg::ST_RELEASE;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr_q[IW-1:0]];
			idx_s1   <= addr_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= vab_pkg::KIND_NOTE_ON;
			note_q   <= '0;
			addr_q   <= '0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			have_q   <= 1'b0;
			chosen_q <= '0;
			lowest_q <= '0;
			rel_q    <= '0;
			act_q    <= '0;
			active_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			v_s1     <= rd_en;
			if (rd_en) begin
				addr_q <= addr_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						note_q   <= note;
						addr_q   <= '0;
						found_q  <= 1'b0;
						have_q   <= 1'b0;
						chosen_q <= '0;
						rel_q    <= '0;
						act_q    <= '0;
						state_q  <= (kind == vab_pkg::KIND_TICK) ? S_STEP : S_SCAN;
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						if (rel_hit) begin
							rel_q <= rel_q + CW'(1);
						end
						if (kind_q == vab_pkg::KIND_NOTE_ON) begin
							if (mono_q) begin
								if (idx_s1 == '0) begin
									found_q  <= (cur.stage == vab_pkg::ST_OFF);
									chosen_q <= '0;
								end
							end else if (!found_q) begin
								if (cur.stage == vab_pkg::ST_OFF) begin
									found_q  <= 1'b1;
									chosen_q <= idx_s1;
								end else if (!have_q || cur.level < lowest_q) begin
									have_q   <= 1'b1;
									lowest_q <= cur.level;
									chosen_q <= idx_s1;
								end
							end
						end
					end
					if (pass_done) begin
						if (kind_q == vab_pkg::KIND_NOTE_ON) begin
							state_q <= S_ONW;
						end else begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_ONW: begin
					active_q <= active_q + CW'(found_q);
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_STEP: begin
					if (v_s1 && stepped.stage != vab_pkg::ST_OFF) begin
						act_q <= act_q + CW'(1);
					end
					if (pass_done) begin
						active_q <= act_q;
						addr_q   <= '0;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (v_s1) begin
						strobe_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && pass_done) begin
			voice_q  <= '0;
			level_q  <= '0;
			stage_q  <= vab_pkg::ST_OFF;
			key_q    <= note_q;
			relout_q <= rel_q;
			actout_q <= active_q;
			last_q   <= 1'b1;
		end else if (state_q == S_ONW) begin
			voice_q  <= vab_pkg::VOICE_W'(chosen_q);
			level_q  <= '0;
			stage_q  <= vab_pkg::ST_ATTACK;
			key_q    <= note_q;
			relout_q <= rel_q;
			actout_q <= active_q + CW'(found_q);
			last_q   <= 1'b1;
		end else if (state_q == S_OUT && v_s1) begin
			voice_q  <= vab_pkg::VOICE_W'(idx_s1);
			level_q  <= cur.level;
			stage_q  <= cur.stage;
			key_q    <= cur.key;
			relout_q <= '0;
			actout_q <= active_q;
			last_q   <= (idx_s1 == IW'(NUM_VOICES - 1));
		end
	end

	assign strobe         = strobe_q;
	assign voice          = voice_q;
	assign level          = level_q;
	assign stage          = stage_q;
	assign voice_note     = key_q;
	assign released_count = vab_pkg::COUNT_W'(relout_q);
	assign active_count   = vab_pkg::COUNT_W'(actout_q);
	assign last           = last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_tick_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside tick results");

	a_onw_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ONW |=> strobe && last)
		else $error("note on without result");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= CW'(NUM_VOICES))
		else $error("active count beyond voice count");

endmodule
